// ----- rtl/core/lct_pkg.sv -----
// Shared types and operation codes for the LRU cache table.
package lct_pkg;

   localparam int KEY_W   = 64;
   localparam int VALUE_W = 64;
   localparam int OP_W    = 3;
   localparam int CAP_W   = 5;

   localparam logic [OP_W-1:0] OP_GET    = 3'd0;
   localparam logic [OP_W-1:0] OP_SET    = 3'd1;
   localparam logic [OP_W-1:0] OP_DELETE = 3'd2;
   localparam logic [OP_W-1:0] OP_EXISTS = 3'd3;
   localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   typedef struct packed {
      logic [OP_W-1:0]    operation;
      logic [KEY_W-1:0]   key;
      logic [VALUE_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic               hit;
      logic [VALUE_W-1:0] read_value;
   } rsp_type;

endpackage

// ----- rtl/core/lru_cache_table.sv -----
// LRU cache table: fully associative key/value store with LRU replacement.
// One operation (get, set, delete, exists, clear) is taken per cycle whenever start is
// high; busy is always low. Each transfer is captured in an input register, looked up
// against all entries in parallel in the next cycle, and its result appears on rsp_data
// with rsp_strobe in the cycle after that, from the result register; one item per cycle
// is sustained by the parallel compare and rank update over the whole table.
// The result is valid for exactly one cycle and cannot be stalled. csr_wdata sets the
// capacity (0 acts as 1, values above ENTRIES act as ENTRIES); write it only while idle.
module lru_cache_table #(
   parameter int ENTRIES    = 16,
   parameter int KEY_BITS   = 64,
   parameter int VALUE_BITS = 64
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  lct_pkg::req_type          req_data,
   output logic                      rsp_strobe,
   output lct_pkg::rsp_type          rsp_data,
   input  logic                      csr_we,
   input  logic [lct_pkg::CAP_W-1:0] csr_wdata
);

   localparam int RANK_W = $clog2(ENTRIES);
   localparam int CMP_W  = (RANK_W + 1 > lct_pkg::CAP_W) ? RANK_W + 1 : lct_pkg::CAP_W;

   logic [lct_pkg::CAP_W-1:0] cap_ff;
   lct_pkg::req_type          req_ff;
   logic                      req_valid_ff;
   lct_pkg::rsp_type          rsp_ff;
   lct_pkg::rsp_type          rsp_in;
   logic                      rsp_strobe_ff;

   logic [ENTRIES-1:0]    valid_ff, valid_in;
   logic [KEY_BITS-1:0]   key_ff   [ENTRIES];
   logic [KEY_BITS-1:0]   key_in   [ENTRIES];
   logic [VALUE_BITS-1:0] value_ff [ENTRIES];
   logic [VALUE_BITS-1:0] value_in [ENTRIES];
   logic [RANK_W-1:0]     rank_ff  [ENTRIES];
   logic [RANK_W-1:0]     rank_in  [ENTRIES];

   logic [KEY_BITS-1:0]   in_key;
   logic [VALUE_BITS-1:0] in_value;
   logic [ENTRIES-1:0]    match;
   logic [ENTRIES-1:0]    keep;
   logic [ENTRIES-1:0]    free_oh;
   logic                  lookup_op;
   logic                  hit;
   logic [RANK_W-1:0]     hit_rank;
   logic [VALUE_BITS-1:0] hit_value;
   logic [CMP_W-1:0]      cap_ext;
   logic [RANK_W-1:0]     lim_m1;

   assign busy     = 1'b0;
   assign in_key   = req_ff.key[KEY_BITS-1:0];
   assign in_value = req_ff.value[VALUE_BITS-1:0];

   // Saturated capacity minus one: a new key keeps only ranks below this.
   always_comb begin
      cap_ext = CMP_W'(cap_ff);
      if (cap_ff == '0) begin
         lim_m1 = '0;
      end else if (cap_ext >= CMP_W'(ENTRIES)) begin
         lim_m1 = RANK_W'(ENTRIES - 1);
      end else begin
         lim_m1 = RANK_W'(cap_ext - CMP_W'(1));
      end
   end

   always_comb begin
      hit_rank  = '0;
      hit_value = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         match[i] = valid_ff[i] && (key_ff[i] == in_key);
         keep[i]  = valid_ff[i] && (rank_ff[i] < lim_m1);
         if (match[i]) begin
            hit_rank  = hit_rank | rank_ff[i];
            hit_value = hit_value | value_ff[i];
         end
      end
      // lowest slot that is empty after eviction
      free_oh = ~keep & (keep + ENTRIES'(1));
   end

   always_comb begin
      lookup_op = (req_ff.operation == lct_pkg::OP_GET)
               || (req_ff.operation == lct_pkg::OP_SET)
               || (req_ff.operation == lct_pkg::OP_DELETE)
               || (req_ff.operation == lct_pkg::OP_EXISTS);
      hit = lookup_op && (|match);
   end

   always_comb begin
      valid_in = valid_ff;
      key_in   = key_ff;
      value_in = value_ff;
      rank_in  = rank_ff;
      rsp_in.hit        = hit;
      rsp_in.read_value = '0;
      if (req_valid_ff) begin
         unique case (req_ff.operation)
            lct_pkg::OP_GET: begin
               if (hit) begin
                  rsp_in.read_value = lct_pkg::VALUE_W'(hit_value);
                  for (int i = 0; i < ENTRIES; i++) begin
                     if (match[i]) begin
                        rank_in[i] = '0;
                     end else if (valid_ff[i] && rank_ff[i] < hit_rank) begin
                        rank_in[i] = rank_ff[i] + RANK_W'(1);
                     end
                  end
               end
            end
            lct_pkg::OP_SET: begin
               for (int i = 0; i < ENTRIES; i++) begin
                  if (hit) begin
                     if (match[i]) begin
                        value_in[i] = in_value;
                        rank_in[i]  = '0;
                     end else if (valid_ff[i] && rank_ff[i] < hit_rank) begin
                        rank_in[i] = rank_ff[i] + RANK_W'(1);
                     end
                  end else if (free_oh[i]) begin
                     valid_in[i] = 1'b1;
                     key_in[i]   = in_key;
                     value_in[i] = in_value;
                     rank_in[i]  = '0;
                  end else if (keep[i]) begin
                     rank_in[i] = rank_ff[i] + RANK_W'(1);
                  end else begin
                     valid_in[i] = 1'b0;
                     rank_in[i]  = '0;
                  end
               end
            end
            lct_pkg::OP_DELETE: begin
               if (hit) begin
                  for (int i = 0; i < ENTRIES; i++) begin
                     if (match[i]) begin
                        valid_in[i] = 1'b0;
                        rank_in[i]  = '0;
                     end else if (valid_ff[i] && rank_ff[i] > hit_rank) begin
                        rank_in[i] = rank_ff[i] - RANK_W'(1);
                     end
                  end
               end
            end
            lct_pkg::OP_CLEAR: begin
               valid_in = '0;
               for (int i = 0; i < ENTRIES; i++) begin
                  rank_in[i] = '0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff        <= lct_pkg::CAP_RESET;
         req_valid_ff  <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         valid_ff      <= '0;
         for (int i = 0; i < ENTRIES; i++) begin
            rank_ff[i] <= '0;
         end
      end else begin
         if (csr_we) begin
            cap_ff <= csr_wdata;
         end
         req_valid_ff  <= start;
         rsp_strobe_ff <= req_valid_ff;
         valid_ff      <= valid_in;
         rank_ff       <= rank_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         req_ff <= req_data;
      end
      rsp_ff   <= rsp_in;
      key_ff   <= key_in;
      value_ff <= value_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

// ----- tb/sv/lru_tracker_pkg.sv -----
// Tracking model of the LRU cache table and the queue of expected responses.
package lru_tracker_pkg;

   import lct_pkg::*;

   localparam int SLOTS = 16;

   // codes the block must treat as no-ops
   localparam logic [OP_W-1:0] OP_RSVD5 = 3'd5;
   localparam logic [OP_W-1:0] OP_RSVD6 = 3'd6;
   localparam logic [OP_W-1:0] OP_RSVD7 = 3'd7;

   class lru_tracker;

      bit                 slot_valid [SLOTS];
      logic [KEY_W-1:0]   slot_key   [SLOTS];
      logic [VALUE_W-1:0] slot_value [SLOTS];
      int unsigned        slot_rank  [SLOTS];
      logic [CAP_W-1:0]   capacity;
      rsp_type            expected_rsps[$];
      int                 fails;

      function new();
         foreach (slot_valid[i]) begin
            slot_valid[i] = 1'b0;
            slot_key[i]   = '0;
            slot_value[i] = '0;
            slot_rank[i]  = 0;
         end
         capacity = CAP_RESET;
         fails    = 0;
      endfunction

      function void set_capacity(logic [CAP_W-1:0] v);
         capacity = v;
      endfunction

      function int pending();
         return expected_rsps.size();
      endfunction

      function int unsigned count_valid();
         int unsigned n;
         n = 0;
         foreach (slot_valid[i])
            if (slot_valid[i])
               n++;
         return n;
      endfunction

      // entries more recent than s age by one, s becomes rank 0
      function void make_recent(int s);
         int unsigned r;
         r = slot_rank[s];
         foreach (slot_valid[i])
            if (slot_valid[i] && slot_rank[i] < r)
               slot_rank[i]++;
         slot_rank[s] = 0;
      endfunction

      // s is dropped, and entries less recent than s move up by one
      function void drop_slot(int s);
         int unsigned r;
         r = slot_rank[s];
         slot_valid[s] = 1'b0;
         slot_rank[s]  = 0;
         foreach (slot_valid[i])
            if (slot_valid[i] && slot_rank[i] > r)
               slot_rank[i]--;
      endfunction

      function void note_request(req_type r);
         rsp_type     o;
         int          s;
         int unsigned lim;
         int unsigned n;
         int          i;
         o = '0;
         s = -1;
         if (r.operation <= OP_EXISTS) begin
            for (i = 0; i < SLOTS; i++) begin
               if (slot_valid[i] && slot_key[i] == r.key) begin
                  s = i;
                  break;
               end
            end
            o.hit = (s >= 0);
         end
         case (r.operation)
            OP_GET: begin
               if (s >= 0) begin
                  o.read_value = slot_value[s];
                  make_recent(s);
               end
            end
            OP_SET: begin
               if (s >= 0) begin
                  slot_value[s] = r.value;
                  make_recent(s);
               end else begin
                  lim = (capacity == 0) ? 1 : (capacity > SLOTS) ? SLOTS : capacity;
                  // evict oldest entries down to lim-1 before inserting
                  while (count_valid() >= lim && count_valid() > 0) begin
                     n = count_valid();
                     for (i = 0; i < SLOTS; i++) begin
                        if (slot_valid[i] && slot_rank[i] + 1 == n) begin
                           drop_slot(i);
                           break;
                        end
                     end
                  end
                  for (i = 0; i < SLOTS; i++) begin
                     if (!slot_valid[i]) begin
                        s = i;
                        break;
                     end
                  end
                  if (s >= 0) begin
                     foreach (slot_valid[j])
                        if (slot_valid[j])
                           slot_rank[j]++;
                     slot_valid[s] = 1'b1;
                     slot_key[s]   = r.key;
                     slot_value[s] = r.value;
                     slot_rank[s]  = 0;
                  end
               end
            end
            OP_DELETE: begin
               if (s >= 0)
                  drop_slot(s);
            end
            OP_CLEAR: begin
               foreach (slot_valid[j]) begin
                  slot_valid[j] = 1'b0;
                  slot_rank[j]  = 0;
               end
            end
            default: ;
         endcase
         expected_rsps.push_back(o);
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         if (expected_rsps.size() == 0) begin
            $error("response with none outstanding: hit %0b read_value %h",
                   got.hit, got.read_value);
            fails++;
            return;
         end
         want = expected_rsps.pop_front();
         if (got.hit !== want.hit) begin
            $error("hit: expected %0b, actual %0b", want.hit, got.hit);
            fails++;
         end
         if (got.read_value !== want.read_value) begin
            $error("read_value: expected %h, actual %h", want.read_value, got.read_value);
            fails++;
         end
      endfunction

   endclass

endpackage

// ----- tb/sv/testbench.sv -----
// Top-level testbench for the LRU cache table: directed and random operation streams.
module testbench;

   timeunit 1ns;
   timeprecision 1ps;

   import lct_pkg::*;
   import lru_tracker_pkg::*;

   localparam int STALL_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 4;

   logic             clock;
   logic             reset;
   logic             start;
   logic             busy;
   req_type          req_data;
   logic             rsp_strobe;
   rsp_type          rsp_data;
   logic             csr_we;
   logic [CAP_W-1:0] csr_wdata;

   lru_tracker tracker = new();
   int         idle_pct;
   int         quiet_cycles;

   lru_cache_table dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // monitor: note accepted requests, check responses
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy)
            tracker.note_request(req_data);
         if (rsp_strobe)
            tracker.check_response(rsp_data);
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("testbench failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] k,
                       input logic [VALUE_W-1:0] v);
      req_type r;
      r.operation = op;
      r.key       = k;
      r.value     = v;
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
   endtask

   // stop issuing and wait until every outstanding transfer has returned
   task automatic drain();
      start <= 1'b0;
      do @(negedge clock); while (tracker.pending() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [CAP_W-1:0] v);
      drain();
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      tracker.set_capacity(v);
   endtask

   task automatic random_run(input logic [CAP_W-1:0] cap, input int pct, input int count);
      logic [KEY_W-1:0]   pool [20];
      logic [OP_W-1:0]    op;
      logic [KEY_W-1:0]   k;
      logic [VALUE_W-1:0] v;
      int                 roll;
      write_capacity(cap);
      idle_pct = pct;
      foreach (pool[i])
         pool[i] = {$urandom, $urandom};
      pool[0] = '0;
      pool[1] = '1;
      repeat (count) begin
         roll = $urandom_range(99);
         if (roll < 30)
            op = OP_GET;
         else if (roll < 62)
            op = OP_SET;
         else if (roll < 72)
            op = OP_DELETE;
         else if (roll < 87)
            op = OP_EXISTS;
         else if (roll < 89)
            op = OP_CLEAR;
         else if (roll < 90)
            op = OP_RSVD5;
         else if (roll < 91)
            op = OP_RSVD6;
         else if (roll < 92)
            op = OP_RSVD7;
         else
            op = OP_SET;
         // mostly keys from a small pool so gets and sets hit
         if ($urandom_range(9) == 0)
            k = {$urandom, $urandom};
         else
            k = pool[$urandom_range(19)];
         roll = $urandom_range(19);
         v = (roll == 0) ? '0 : (roll == 1) ? '1 : {$urandom, $urandom};
         send(op, k, v);
      end
   endtask

   initial begin
      reset     <= 1'b1;
      start     <= 1'b0;
      req_data  <= '0;
      csr_we    <= 1'b0;
      csr_wdata <= '0;
      idle_pct  = 11;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: empty store, key/value extremes, every operation, no-op codes
      send(OP_GET, '0, '0);
      send(OP_SET, '0, '1);
      send(OP_SET, '1, '0);
      send(OP_GET, '0, '0);
      send(OP_GET, '1, '1);
      send(OP_EXISTS, '0, '1);
      send(OP_SET, '0, 64'h0123_4567_89ab_cdef);
      send(OP_GET, '0, '0);
      send(OP_DELETE, '1, '0);
      send(OP_DELETE, '1, '0);
      send(OP_EXISTS, '1, '0);
      send(OP_RSVD5, '0, '1);
      send(OP_RSVD6, '0, '1);
      send(OP_RSVD7, '1, '1);
      send(OP_CLEAR, '0, '0);
      send(OP_GET, '0, '0);
      // capacity zero acts as one: second insert evicts the first
      write_capacity('0);
      send(OP_SET, 64'h5a5a, 64'h1111);
      send(OP_SET, 64'ha5a5, 64'h2222);
      send(OP_GET, 64'h5a5a, '0);
      send(OP_GET, 64'ha5a5, '0);

      random_run(5'd16, 11, 200);
      random_run(5'd3, 11, 180);   // lowered below occupancy
      random_run(5'd0, 11, 150);
      random_run(5'd31, 48, 200);
      random_run(5'd1, 48, 150);
      random_run(5'd17, 48, 150);
      random_run(5'd9, 0, 200);
      random_run(5'd2, 0, 150);
      random_run(5'd16, 0, 50);

      drain();
      if (tracker.fails == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

endmodule

// ----- files.f -----
rtl/core/lct_pkg.sv
rtl/core/lru_cache_table.sv
tb/sv/lru_tracker_pkg.sv
tb/sv/testbench.sv
